// ===== src/lorenz_euler_step_unit_defines.svh =====
// Assertion macros shared by the Lorenz Euler step unit.
`ifndef LORENZ_EULER_STEP_UNIT_DEFINES_SVH
`define LORENZ_EULER_STEP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Lorenz step unit assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define LES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Lorenz step unit assertion failed.");

`endif

// ===== src/les_pkg.sv =====
// Types, constants and the microcode table of the Lorenz Euler step unit.
`timescale 1ns / 1ps
`default_nettype none
package les_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam int DIFF_BITS = WORD_BITS + 1;
   localparam int DT_BITS   = FRAC_BITS + 1;
   localparam int A_BITS    = WORD_BITS;
   localparam int B_BITS    = 2 * WORD_BITS - FRAC_BITS;
   localparam int B_LO      = (B_BITS + 1) / 2;
   localparam int B_HI      = B_BITS - B_LO;
   localparam int PP_BITS   = A_BITS + B_LO;
   localparam int P_BITS    = 2 * WORD_BITS + 2;
   localparam int ACC_BITS  = P_BITS - FRAC_BITS + 2;

   localparam int CSR_IDX_BITS = 3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;
   typedef logic [DT_BITS-1:0]          dt_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam longint ONE = longint'(1) << FRAC_BITS;
   localparam word_type RST_SIGMA = WORD_BITS'(ONE * 10);
   localparam word_type RST_RHO   = WORD_BITS'(ONE * 28);
   localparam word_type RST_BETA  = WORD_BITS'((ONE * 8 + 1) / 3);
   localparam dt_type   RST_DT    = DT_BITS'((ONE + 50) / 100);
   localparam word_type RST_X     = WORD_BITS'(ONE);
   localparam word_type RST_Y     = WORD_BITS'((ONE * 31 + 5) / 10);
   localparam word_type RST_Z     = '0;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SIGMA,
      REG_RHO,
      REG_BETA,
      REG_DT,
      REG_START_X,
      REG_START_Y,
      REG_START_Z
   } csr_idx_type;

   typedef enum logic [1:0] {A_SIGMA, A_X, A_BETA, A_DT} asel_type;
   typedef enum logic [2:0] {B_DXY, B_DRZ, B_Y, B_Z, B_DX, B_DY, B_DZ} bsel_type;
   typedef enum logic [2:0] {W_DX, W_DY, W_T, W_DZ, W_X, W_Y, W_Z} wdst_type;
   typedef enum logic [1:0] {N_SEQ, N_JUMP, N_EMIT} next_type;

   localparam int ROM_DEPTH = 21;
   localparam int PC_BITS   = $clog2(ROM_DEPTH);

   localparam logic [PC_BITS-1:0] ADDR_STEP = PC_BITS'(0);
   localparam logic [PC_BITS-1:0] ADDR_EMIT = PC_BITS'(19);
   localparam logic [PC_BITS-1:0] ADDR_LOAD = PC_BITS'(20);

   typedef struct packed {
      logic               diff;
      logic               load;
      logic               issue;
      asel_type           asel;
      bsel_type           bsel;
      logic               wb;
      wdst_type           wdst;
      next_type           nxt;
      logic [PC_BITS-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic              start;
      logic              neg;
      logic [A_BITS-1:0] a_mag;
      logic [B_BITS-1:0] b_mag;
   } mul_req_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
      logic     clip;
   } state_type;

   function automatic ctrl_type cw_base();
      ctrl_type c;
      c.diff   = 1'b0;
      c.load   = 1'b0;
      c.issue  = 1'b0;
      c.asel   = A_SIGMA;
      c.bsel   = B_DXY;
      c.wb     = 1'b0;
      c.wdst   = W_DX;
      c.nxt    = N_SEQ;
      c.target = ADDR_STEP;
      return c;
   endfunction

   function automatic ctrl_type cw_issue(asel_type a, bsel_type b);
      ctrl_type c;
      c       = cw_base();
      c.issue = 1'b1;
      c.asel  = a;
      c.bsel  = b;
      return c;
   endfunction

   function automatic ctrl_type cw_wb(wdst_type d);
      ctrl_type c;
      c      = cw_base();
      c.wb   = 1'b1;
      c.wdst = d;
      return c;
   endfunction

   // Products are issued at the odd addresses 1 to 13 and written back at the even addresses 6 to 18.
   function automatic ctrl_type les_rom(logic [PC_BITS-1:0] addr);
      ctrl_type c;
      c = cw_base();
      case (addr)
         PC_BITS'(0): c.diff = 1'b1;
         PC_BITS'(1): c = cw_issue(A_SIGMA, B_DXY);
         PC_BITS'(3): c = cw_issue(A_X, B_DRZ);
         PC_BITS'(5): c = cw_issue(A_X, B_Y);
         PC_BITS'(6): c = cw_wb(W_DX);
         PC_BITS'(7): c = cw_issue(A_BETA, B_Z);
         PC_BITS'(8): c = cw_wb(W_DY);
         PC_BITS'(9): c = cw_issue(A_DT, B_DX);
         PC_BITS'(10): c = cw_wb(W_T);
         PC_BITS'(11): c = cw_issue(A_DT, B_DY);
         PC_BITS'(12): c = cw_wb(W_DZ);
         PC_BITS'(13): c = cw_issue(A_DT, B_DZ);
         PC_BITS'(14): c = cw_wb(W_X);
         PC_BITS'(16): c = cw_wb(W_Y);
         PC_BITS'(18): c = cw_wb(W_Z);
         PC_BITS'(19): c.nxt = N_EMIT;
         PC_BITS'(20): begin
            c.load   = 1'b1;
            c.nxt    = N_JUMP;
            c.target = ADDR_EMIT;
         end
         PC_BITS'(2), PC_BITS'(4), PC_BITS'(15), PC_BITS'(17): c = cw_base();
         default: begin
            c.nxt    = N_JUMP;
            c.target = ADDR_EMIT;
         end
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== src/les_mul.sv =====
// Shared sign-magnitude fixed-point multiplier with rounding, two passes per product.
`timescale 1ns / 1ps
`default_nettype none
`include "lorenz_euler_step_unit_defines.svh"
module les_mul (
   input  logic                clock,
   input  logic                reset,
   input  les_pkg::mul_req_type req,
   output les_pkg::acc_type    res
);
   import les_pkg::*;

   localparam logic [P_BITS-1:0] HALF = P_BITS'(1) << (FRAC_BITS - 1);

   logic [A_BITS-1:0]  a_ff, a_in;
   logic [B_BITS-1:0]  b_ff, b_in;
   logic               neg_ff, neg_in;
   logic               lo_ph_ff, lo_ph_in;
   logic               hi_ph_ff, hi_ph_in;
   logic               sum_ph_ff, sum_ph_in;
   logic               res_ph_ff, res_ph_in;
   logic [PP_BITS-1:0] plo_ff, plo_in;
   logic [PP_BITS-1:0] phi_ff, phi_in;
   logic               negp_ff, negp_in;
   logic [P_BITS-1:0]  sum_ff, sum_in;
   logic               negs_ff, negs_in;
   acc_type            res_ff, res_in;
   logic [B_LO-1:0]    mul_b;
   logic [PP_BITS-1:0] prod;
   acc_type            rnd;

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      negp_in   = negp_ff;
      sum_in    = sum_ff;
      negs_in   = negs_ff;
      res_in    = res_ff;
      lo_ph_in  = req.start;
      hi_ph_in  = lo_ph_ff;
      sum_ph_in = hi_ph_ff;
      res_ph_in = sum_ph_ff;

      mul_b = hi_ph_ff ? B_LO'(b_ff[B_BITS-1:B_LO]) : b_ff[B_LO-1:0];
      prod  = PP_BITS'(a_ff) * PP_BITS'(mul_b);
      rnd   = ACC_BITS'(sum_ff[P_BITS-1:FRAC_BITS]);

      if (req.start) begin
         a_in   = req.a_mag;
         b_in   = req.b_mag;
         neg_in = req.neg;
      end
      if (lo_ph_ff) begin
         plo_in = prod;
      end
      if (hi_ph_ff) begin
         phi_in  = prod;
         negp_in = neg_ff;
      end
      if (sum_ph_ff) begin
         sum_in  = P_BITS'(plo_ff) + (P_BITS'(phi_ff) << B_LO) + HALF;
         negs_in = negp_ff;
      end
      if (res_ph_ff) begin
         res_in = negs_ff ? -rnd : rnd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ph_ff  <= 1'b0;
         hi_ph_ff  <= 1'b0;
         sum_ph_ff <= 1'b0;
         res_ph_ff <= 1'b0;
      end else begin
         lo_ph_ff  <= lo_ph_in;
         hi_ph_ff  <= hi_ph_in;
         sum_ph_ff <= sum_ph_in;
         res_ph_ff <= res_ph_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      neg_ff  <= neg_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      negp_ff <= negp_in;
      sum_ff  <= sum_in;
      negs_ff <= negs_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

   `LES_ASSERT_IMPL(a_issue_gap, clock, reset, req.start, !lo_ph_ff)
   `LES_ASSERT_IMPL(a_res_timing, clock, reset, res_ph_ff, $past(req.start, 4))

endmodule
`default_nettype wire

// ===== src/les_dpath.sv =====
// Datapath: configuration registers, Lorenz state, temporaries and the shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module les_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [les_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [les_pkg::WORD_BITS-1:0]     csr_wdata,
   input  les_pkg::ctrl_type                 ctrl,
   output les_pkg::state_type                state
);
   import les_pkg::*;

   localparam acc_type ACC_WMAX = ACC_BITS'(WORD_MAX);
   localparam acc_type ACC_WMIN = ACC_BITS'(WORD_MIN);

   word_type    sigma_ff, sigma_in;
   word_type    rho_ff, rho_in;
   word_type    beta_ff, beta_in;
   dt_type      dt_ff, dt_in;
   word_type    sx_ff, sx_in;
   word_type    sy_ff, sy_in;
   word_type    sz_ff, sz_in;
   word_type    x_ff, x_in;
   word_type    y_ff, y_in;
   word_type    z_ff, z_in;
   logic        clip_ff, clip_in;
   diff_type    dxy_ff, dxy_in;
   diff_type    drz_ff, drz_in;
   acc_type     dx_ff, dx_in;
   acc_type     dy_ff, dy_in;
   acc_type     t_ff, t_in;
   acc_type     dz_ff, dz_in;
   diff_type    a_val, a_abs;
   acc_type     b_val, b_abs;
   mul_req_type mreq;
   acc_type     mul_res;
   word_type    base;
   acc_type     sum;
   word_type    sat_val;
   logic        sat_ov;

   les_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .res   (mul_res)
   );

   always_comb begin
      case (ctrl.asel)
         A_SIGMA: a_val = DIFF_BITS'(sigma_ff);
         A_X:     a_val = DIFF_BITS'(x_ff);
         A_BETA:  a_val = DIFF_BITS'(beta_ff);
         A_DT:    a_val = $signed(DIFF_BITS'(dt_ff));
         default: a_val = DIFF_BITS'(x_ff);
      endcase
      case (ctrl.bsel)
         B_DXY:   b_val = ACC_BITS'(dxy_ff);
         B_DRZ:   b_val = ACC_BITS'(drz_ff);
         B_Y:     b_val = ACC_BITS'(y_ff);
         B_Z:     b_val = ACC_BITS'(z_ff);
         B_DX:    b_val = dx_ff;
         B_DY:    b_val = dy_ff;
         B_DZ:    b_val = dz_ff;
         default: b_val = dx_ff;
      endcase
      a_abs      = a_val[DIFF_BITS-1] ? -a_val : a_val;
      b_abs      = b_val[ACC_BITS-1] ? -b_val : b_val;
      mreq.start = ctrl.issue;
      mreq.neg   = a_val[DIFF_BITS-1] ^ b_val[ACC_BITS-1];
      mreq.a_mag = a_abs[A_BITS-1:0];
      mreq.b_mag = b_abs[B_BITS-1:0];
   end

   always_comb begin
      case (ctrl.wdst)
         W_Y:     base = y_ff;
         W_Z:     base = z_ff;
         default: base = x_ff;
      endcase
      sum = ACC_BITS'(base) + mul_res;
      if (sum > ACC_WMAX) begin
         sat_val = WORD_MAX;
         sat_ov  = 1'b1;
      end else if (sum < ACC_WMIN) begin
         sat_val = WORD_MIN;
         sat_ov  = 1'b1;
      end else begin
         sat_val = sum[WORD_BITS-1:0];
         sat_ov  = 1'b0;
      end
   end

   always_comb begin
      sigma_in = sigma_ff;
      rho_in   = rho_ff;
      beta_in  = beta_ff;
      dt_in    = dt_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sz_in    = sz_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            REG_SIGMA:   sigma_in = csr_wdata;
            REG_RHO:     rho_in   = csr_wdata;
            REG_BETA:    beta_in  = csr_wdata;
            REG_DT:      dt_in    = csr_wdata[DT_BITS-1:0];
            REG_START_X: sx_in    = csr_wdata;
            REG_START_Y: sy_in    = csr_wdata;
            REG_START_Z: sz_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      clip_in = clip_ff;
      dxy_in  = dxy_ff;
      drz_in  = drz_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      t_in    = t_ff;
      dz_in   = dz_ff;
      if (ctrl.diff) begin
         dxy_in  = DIFF_BITS'(y_ff) - DIFF_BITS'(x_ff);
         drz_in  = DIFF_BITS'(rho_ff) - DIFF_BITS'(z_ff);
         clip_in = 1'b0;
      end
      if (ctrl.load) begin
         x_in    = sx_ff;
         y_in    = sy_ff;
         z_in    = sz_ff;
         clip_in = 1'b0;
      end
      if (ctrl.wb) begin
         case (ctrl.wdst)
            W_DX: dx_in = mul_res;
            W_DY: dy_in = mul_res - ACC_BITS'(y_ff);
            W_T:  t_in  = mul_res;
            W_DZ: dz_in = t_ff - mul_res;
            W_X: begin
               x_in    = sat_val;
               clip_in = clip_ff | sat_ov;
            end
            W_Y: begin
               y_in    = sat_val;
               clip_in = clip_ff | sat_ov;
            end
            W_Z: begin
               z_in    = sat_val;
               clip_in = clip_ff | sat_ov;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= RST_SIGMA;
         rho_ff   <= RST_RHO;
         beta_ff  <= RST_BETA;
         dt_ff    <= RST_DT;
         sx_ff    <= RST_X;
         sy_ff    <= RST_Y;
         sz_ff    <= RST_Z;
         x_ff     <= RST_X;
         y_ff     <= RST_Y;
         z_ff     <= RST_Z;
         clip_ff  <= 1'b0;
      end else begin
         sigma_ff <= sigma_in;
         rho_ff   <= rho_in;
         beta_ff  <= beta_in;
         dt_ff    <= dt_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sz_ff    <= sz_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         clip_ff  <= clip_in;
      end
      dxy_ff <= dxy_in;
      drz_ff <= drz_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      t_ff   <= t_in;
      dz_ff  <= dz_in;
   end

   assign state.x    = x_ff;
   assign state.y    = y_ff;
   assign state.z    = z_ff;
   assign state.clip = clip_ff;

endmodule
`default_nettype wire

// ===== src/les_seq.sv =====
// Microcode sequencer: step counter, control table lookup and jumps.
`timescale 1ns / 1ps
`default_nettype none
`include "lorenz_euler_step_unit_defines.svh"
module les_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_restart,
   input  logic              slot_free,
   output logic              req_ready,
   output les_pkg::ctrl_type ctrl,
   output logic              emit
);
   import les_pkg::*;

   logic               busy_ff, busy_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   ctrl_type           cw;

   always_comb begin
      cw      = les_rom(pc_ff);
      busy_in = busy_ff;
      pc_in   = pc_ff;
      emit    = 1'b0;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in = 1'b1;
            pc_in   = req_restart ? ADDR_LOAD : ADDR_STEP;
         end
      end else begin
         case (cw.nxt)
            N_SEQ:  pc_in = pc_ff + PC_BITS'(1);
            N_JUMP: pc_in = cw.target;
            N_EMIT: begin
               if (slot_free) begin
                  emit    = 1'b1;
                  busy_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
      ctrl = busy_ff ? cw : cw_base();
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= ADDR_STEP;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign req_ready = !busy_ff;

   `LES_ASSERT_IMPL(a_emit_busy, clock, reset, emit, busy_ff)
   `LES_ASSERT_NEXT(a_emit_frees, clock, reset, emit, req_ready)
   `LES_ASSERT_IMPL(a_pc_range, clock, reset, busy_ff, pc_ff <= ADDR_LOAD)

endmodule
`default_nettype wire

// ===== src/lorenz_euler_step_unit.sv =====
// Lorenz Euler step unit: one explicit Euler step of x, y, z in Q16.16 per step request beat;
// a restart beat loads the start state instead. One beat is worked at a time, and a response
// waits while the response slot is full. Seven products share one 32 by 24 multiplier that
// needs two passes per product, behind a four-stage pipeline.
// Synchronous reset restores the default coefficients and start state, with no beat pending.
`timescale 1ns / 1ps
`default_nettype none
`include "lorenz_euler_step_unit_defines.svh"
module lorenz_euler_step_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output les_pkg::word_type                rsp_out_x,
   output les_pkg::word_type                rsp_out_y,
   output les_pkg::word_type                rsp_out_z,
   output logic                             rsp_clipped,
   input  logic                             csr_we,
   input  logic [les_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [les_pkg::WORD_BITS-1:0]    csr_wdata
);
   import les_pkg::*;

   ctrl_type  ctrl;
   state_type state;
   logic      emit;
   logic      slot_free;
   logic      rsp_valid_ff, rsp_valid_in;
   state_type rsp_ff, rsp_in;

   les_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .slot_free   (slot_free),
      .req_ready   (req_ready),
      .ctrl        (ctrl),
      .emit        (emit)
   );

   les_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .state     (state)
   );

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_ready;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_in       = state;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_x   = rsp_ff.x;
   assign rsp_out_y   = rsp_ff.y;
   assign rsp_out_z   = rsp_ff.z;
   assign rsp_clipped = rsp_ff.clip;

   `LES_ASSERT_IMPL(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !emit)

endmodule
`default_nettype wire
